// File: hw/rtl/chbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbt_pkg
// Shared types and constants for the chained hash bucket table.
// ----------------------------------------------------------------------------
package chbt_pkg;

	// Offset added to the status before the bucket reduction
	localparam int HASH_OFFSET = 10;
	// Number of distinct status codes
	localparam int STATUS_VALUES = 256;

	// Field widths
	localparam int CLIENT_W = 16;
	localparam int STATUS_W = 8;
	localparam int DAY_W    = 16;
	localparam int ID_W     = 6;
	localparam int REC_W    = CLIENT_W + STATUS_W + DAY_W;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (ID_W + REC_W);

	// Item kind carried on the input tuser
	typedef enum logic {
		KIND_INSERT = 1'b0,
		KIND_QUERY  = 1'b1
	} kind_t;

	// Control sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

endpackage : chbt_pkg
`default_nettype wire

// File: hw/rtl/chbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbt_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chbt_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule : chbt_ram
`default_nettype wire

// File: hw/rtl/chbt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chbt_ctrl
// Bucket head/tail registers, slot allocation, chain walk sequencer and the
// result output register.
// ----------------------------------------------------------------------------
module chbt_ctrl import chbt_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int BUCKETS  = 7,
	localparam int SW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int BW = $clog2(BUCKETS)
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic                   s_tuser,
	input  wire logic [BW-1:0]          bucket,
	// output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tuser,
	output logic                        m_tlast,
	// record and link memories
	output logic                        rec_we,
	output logic [SW-1:0]               rec_waddr,
	input  wire logic [REC_W-1:0]       rec_rdata,
	output logic                        link_we,
	output logic [SW-1:0]               link_waddr,
	output logic [SW-1:0]               link_wdata,
	output logic                        rd_en,
	output logic [SW-1:0]               rd_addr,
	input  wire logic [SW-1:0]          link_rdata
);

	state_t state_q, state_d;

	logic [CW-1:0]      count_q;
	logic [BUCKETS-1:0] head_valid_q;
	logic [SW-1:0]      head_q [BUCKETS];
	logic [SW-1:0]      tail_q [BUCKETS];
	logic [SW-1:0]      cur_q;
	logic [SW-1:0]      walk_tail_q;

	logic                m_valid_q;
	logic                ok_q;
	logic                last_q;
	logic [ID_W-1:0]     id_q;
	logic [CLIENT_W-1:0] client_q;
	logic [STATUS_W-1:0] status_q;
	logic [DAY_W-1:0]    day_q;

	logic          out_free;
	logic          acc;
	logic          is_ins;
	logic          full;
	logic          hv;
	logic [SW-1:0] head_rd;
	logic [SW-1:0] tail_rd;
	logic [SW-1:0] new_slot;
	logic          ins_ok;
	logic          walk_last;
	logic          load_ack;
	logic          load_rec;

	// Handshake and lookup of the addressed bucket
	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign acc       = s_tvalid && s_tready;
	assign is_ins    = (s_tuser == KIND_INSERT);
	assign full      = (count_q == CW'(CAPACITY));
	assign hv        = head_valid_q[bucket];
	assign head_rd   = head_q[bucket];
	assign tail_rd   = tail_q[bucket];
	assign new_slot  = count_q[SW-1:0];
	assign ins_ok    = acc && is_ins && !full;
	assign walk_last = (cur_q == walk_tail_q);

	// Insert writes: record into the new slot, link from the old tail
	assign rec_we     = ins_ok;
	assign rec_waddr  = new_slot;
	assign link_we    = ins_ok && hv;
	assign link_waddr = tail_rd;
	assign link_wdata = new_slot;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && !is_ins && hv) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (out_free && walk_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory reads and output loads
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = head_rd;
		load_ack = 1'b0;
		load_rec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (is_ins || !hv) begin
						load_ack = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = head_rd;
					end
				end
			end
			ST_WALK: begin
				if (out_free) begin
					load_rec = 1'b1;
					if (!walk_last) begin
						rd_en   = 1'b1;
						rd_addr = link_rdata;
					end
				end
			end
			default: ;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			head_valid_q <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_ok) begin
				count_q <= count_q + CW'(1);
				if (!hv) begin
					head_valid_q[bucket] <= 1'b1;
				end
			end
			if (load_ack || load_rec) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Bucket pointers and walk position
	always_ff @(posedge clk) begin
		if (ins_ok) begin
			if (!hv) begin
				head_q[bucket] <= new_slot;
			end
			tail_q[bucket] <= new_slot;
		end
		if (rd_en) begin
			cur_q <= rd_addr;
		end
		if (acc && !is_ins) begin
			walk_tail_q <= tail_rd;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load_ack) begin
			ok_q     <= ins_ok;
			id_q     <= ins_ok ? ID_W'(7'(new_slot) + 7'd1) : '0;
			client_q <= '0;
			status_q <= '0;
			day_q    <= '0;
			last_q   <= 1'b1;
		end else if (load_rec) begin
			ok_q     <= 1'b1;
			id_q     <= ID_W'(7'(cur_q) + 7'd1);
			client_q <= rec_rdata[CLIENT_W-1:0];
			status_q <= rec_rdata[CLIENT_W+STATUS_W-1:CLIENT_W];
			day_q    <= rec_rdata[REC_W-1:CLIENT_W+STATUS_W];
			last_q   <= walk_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, day_q, status_q, client_q, id_q};

endmodule : chbt_ctrl
`default_nettype wire

// File: hw/rtl/chained_hash_bucket_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// An insert or an empty-bucket query gives its single result in the cycle after
// acceptance; a query's first record passes the memory read and output registers.
// While the output is taken, inserts take one item per cycle and a query emits one
// record per cycle via the link read loop and blocks input until its last record.
// Reset (arst_n, async): empties all buckets and the slot count; the record and
// link memories are not cleared.
// ----------------------------------------------------------------------------
// chained_hash_bucket_table_core
// Hash table with separate chaining over a fixed pool of record slots.
// ----------------------------------------------------------------------------
module chained_hash_bucket_table_core import chbt_pkg::*; #(
	parameter int CAPACITY = 32,
	parameter int BUCKETS  = 7
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // client, status, launch_day
	input  wire logic                   s_tuser,   // kind
	// output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // order_id, out_client, out_status,
	                                               // out_day, zero pad
	output logic                        m_tuser,   // ok
	output logic                        m_tlast    // last
);

	localparam int SW = $clog2(CAPACITY);
	localparam int BW = $clog2(BUCKETS);

	logic [BW-1:0]    bkt_lut [STATUS_VALUES];
	logic [BW-1:0]    bucket;
	logic             rec_we;
	logic [SW-1:0]    rec_waddr;
	logic [REC_W-1:0] rec_rdata;
	logic             link_we;
	logic [SW-1:0]    link_waddr;
	logic [SW-1:0]    link_wdata;
	logic             rd_en;
	logic [SW-1:0]    rd_addr;
	logic [SW-1:0]    link_rdata;

	// Bucket table: (status + offset) mod BUCKETS, fixed at elaboration
	for (genvar g = 0; g < STATUS_VALUES; g++) begin : g_bkt
		assign bkt_lut[g] = BW'((g + HASH_OFFSET) % BUCKETS);
	end
	assign bucket = bkt_lut[s_tdata[CLIENT_W+STATUS_W-1:CLIENT_W]];

	chbt_ctrl #(
		.CAPACITY (CAPACITY),
		.BUCKETS  (BUCKETS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.bucket     (bucket),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.rec_we     (rec_we),
		.rec_waddr  (rec_waddr),
		.rec_rdata  (rec_rdata),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.link_rdata (link_rdata)
	);

	// Record store: client, status, day per slot
	chbt_ram #(
		.WIDTH (REC_W),
		.DEPTH (CAPACITY)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (s_tdata[REC_W-1:0]),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rec_rdata)
	);

	// Chain successor per slot
	chbt_ram #(
		.WIDTH (SW),
		.DEPTH (CAPACITY)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

`ifndef SYNTH
	// Input is taken only when the output register can accept a result
	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input accepted while output register blocked");

	// A chain walk read never coincides with an insert write
	a_no_rd_wr: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (!rec_we && !link_we))
		else $error("memory read overlaps insert write");

	// The tail link written by an insert never targets the new slot
	a_link_slot: assert property (@(posedge clk) disable iff (!arst_n)
		link_we |-> (link_waddr != rec_waddr))
		else $error("link write hits the newly allocated slot");

	// An accepted insert is acknowledged in the next cycle as a single last beat
	a_ins_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == KIND_INSERT) |=>
		(m_tvalid && m_tlast && m_tdata[OUT_TDATA_W-1:ID_W] == '0))
		else $error("insert acknowledgement missing or malformed");
`endif

endmodule : chained_hash_bucket_table_core
`default_nettype wire
